### hw/rtl/tgard_pkg.sv
// Shared types and constants for the TGA run-length stream decoder.
package tgard_pkg;

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_SKIP_ID = 5'b00010,
      PH_PACKET  = 5'b00100,
      PH_PIXEL   = 5'b01000,
      PH_IDLE    = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_COLORMAP  = 3'd1,
      ERR_ENCODING  = 3'd2,
      ERR_SIZE      = 3'd3,
      ERR_DEPTH     = 3'd4,
      ERR_TRUNCATED = 3'd5
   } err_type;

   // header byte positions
   localparam logic [4:0] HDR_ID_LEN   = 5'd0;
   localparam logic [4:0] HDR_CMAP     = 5'd1;
   localparam logic [4:0] HDR_TYPE     = 5'd2;
   localparam int         HDR_COORD0   = 8;
   localparam logic [4:0] HDR_DEPTH    = 5'd16;
   localparam logic [4:0] HDR_LAST     = 5'd17;

   localparam logic [7:0] TYPE_RAW     = 8'd2;
   localparam logic [7:0] TYPE_RLE     = 8'd10;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam logic [7:0] DESC_MAX     = 8'd32;
   localparam int         FLIP_BIT     = 4;
   localparam int         RUN_BIT      = 7;
   localparam logic [7:0] RUN_BIAS     = 8'd127;
   localparam logic signed [16:0] DIM_MAX = 17'sd32767;
   localparam logic signed [16:0] DIM_MIN = 17'sd1;

   typedef struct packed {
      phase_type   phase;
      logic [4:0]  hdr_idx;
      logic [7:0]  id_left;
      logic [63:0] coord;
      logic        rle;
      logic        bpp4;
      logic        run;
      logic [7:0]  pkt_left;
      logic [1:0]  byte_idx;
      logic [31:0] pix;
      logic [29:0] pix_left;
      logic        flip;
      logic [7:0]  cmap;
      logic [7:0]  itype;
      logic [7:0]  depth;
   } state_type;

   localparam state_type ST_RESET = '{
      phase:    PH_HEADER,
      hdr_idx:  5'd0,
      id_left:  8'd0,
      coord:    64'd0,
      rle:      1'b0,
      bpp4:     1'b1,
      run:      1'b0,
      pkt_left: 8'd0,
      byte_idx: 2'd0,
      pix:      32'd0,
      pix_left: 30'd0,
      flip:     1'b0,
      cmap:     8'd0,
      itype:    8'd0,
      depth:    8'd0
   };

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [14:0] width;
      logic [14:0] height;
      logic [5:0]  bpp;
      logic        flip;
      err_type     err;
      logic        last;
   } result_type;

endpackage

### hw/rtl/tgard_parser.sv
// Parse state and per-byte decode step: header, ID skip, packets and pixels.
module tgard_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           file_byte,
   input  logic                 first_byte,
   input  logic                 final_byte,
   output logic                 has_result,
   output tgard_pkg::result_type result
);
   import tgard_pkg::*;

   state_type         st_ff;
   state_type         st_in;
   state_type         cur;
   logic signed [16:0] w_diff;
   logic signed [16:0] h_diff;
   logic [29:0]       pix_total;
   logic [31:0]       pix_merged;
   logic [2:0]        bytes_needed;
   logic [7:0]        count;
   logic [7:0]        pkt_next;
   logic [29:0]       left_next;
   logic              size_bad;

   always_comb begin
      cur = first_byte ? ST_RESET : st_ff;

      w_diff = $signed({cur.coord[47], cur.coord[47:32]})
             - $signed({cur.coord[15], cur.coord[15:0]});
      h_diff = $signed({cur.coord[63], cur.coord[63:48]})
             - $signed({cur.coord[31], cur.coord[31:16]});
      size_bad = (w_diff < DIM_MIN) || (h_diff < DIM_MIN)
              || (w_diff > DIM_MAX) || (h_diff > DIM_MAX);
      pix_total = w_diff[14:0] * h_diff[14:0];

      pix_merged   = cur.pix | ({24'd0, file_byte} << {cur.byte_idx, 3'b000});
      bytes_needed = cur.bpp4 ? 3'd4 : 3'd3;

      // run length clipped at image end
      if (cur.rle && cur.run) begin
         count    = ({22'd0, cur.pkt_left} > cur.pix_left) ? cur.pix_left[7:0]
                                                           : cur.pkt_left;
         pkt_next = 8'd0;
      end else begin
         count    = 8'd1;
         pkt_next = (cur.rle && cur.pkt_left != 8'd0) ? cur.pkt_left - 8'd1
                                                     : cur.pkt_left;
      end
      left_next = cur.pix_left - {22'd0, count};

      st_in      = cur;
      result     = '0;
      has_result = 1'b0;

      unique case (cur.phase)
         PH_HEADER: begin
            if (cur.hdr_idx == HDR_ID_LEN) st_in.id_left = file_byte;
            if (cur.hdr_idx == HDR_CMAP) st_in.cmap = file_byte;
            if (cur.hdr_idx == HDR_TYPE) st_in.itype = file_byte;
            if (cur.hdr_idx == HDR_DEPTH) st_in.depth = file_byte;
            for (int k = 0; k < 8; k++) begin
               if (cur.hdr_idx == 5'(HDR_COORD0 + k)) st_in.coord[8*k +: 8] = file_byte;
            end
            if (cur.hdr_idx == HDR_LAST) begin
               has_result = 1'b1;
               priority if (cur.cmap > 8'd1) begin
                  result.kind = KIND_ERROR;
                  result.err  = ERR_COLORMAP;
               end else if (cur.itype != TYPE_RAW && cur.itype != TYPE_RLE) begin
                  result.kind = KIND_ERROR;
                  result.err  = ERR_ENCODING;
               end else if (size_bad) begin
                  result.kind = KIND_ERROR;
                  result.err  = ERR_SIZE;
               end else if (file_byte > DESC_MAX
                            || (cur.depth != DEPTH_24 && cur.depth != DEPTH_32)) begin
                  result.kind = KIND_ERROR;
                  result.err  = ERR_DEPTH;
               end else if (cur.cmap != 8'd0) begin
                  result.kind = KIND_ERROR;
                  result.err  = ERR_COLORMAP;
               end else begin
                  result.kind   = KIND_HEADER;
                  result.width  = w_diff[14:0];
                  result.height = h_diff[14:0];
                  result.bpp    = cur.depth[5:0];
                  result.flip   = file_byte[FLIP_BIT];
               end
               if (result.kind == KIND_ERROR) begin
                  st_in.phase = PH_IDLE;
               end else begin
                  st_in.rle      = (cur.itype == TYPE_RLE);
                  st_in.bpp4     = (cur.depth == DEPTH_32);
                  st_in.flip     = file_byte[FLIP_BIT];
                  st_in.pix_left = pix_total;
                  st_in.run      = 1'b0;
                  st_in.byte_idx = 2'd0;
                  st_in.pix      = 32'd0;
                  if (cur.id_left != 8'd0) begin
                     st_in.phase = PH_SKIP_ID;
                  end else begin
                     st_in.phase = (cur.itype == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
                  end
               end
            end else begin
               st_in.hdr_idx = cur.hdr_idx + 5'd1;
            end
         end
         PH_SKIP_ID: begin
            st_in.id_left = cur.id_left - 8'd1;
            if (cur.id_left == 8'd1) begin
               st_in.phase    = cur.rle ? PH_PACKET : PH_PIXEL;
               st_in.run      = 1'b0;
               st_in.byte_idx = 2'd0;
               st_in.pix      = 32'd0;
            end
         end
         PH_PACKET: begin
            if (file_byte[RUN_BIT]) begin
               st_in.run      = 1'b1;
               st_in.pkt_left = file_byte - RUN_BIAS;
            end else begin
               st_in.run      = 1'b0;
               st_in.pkt_left = file_byte + 8'd1;
            end
            st_in.phase    = PH_PIXEL;
            st_in.byte_idx = 2'd0;
            st_in.pix      = 32'd0;
         end
         PH_PIXEL: begin
            if ({1'b0, cur.byte_idx} + 3'd1 >= bytes_needed) begin
               has_result          = 1'b1;
               result.kind         = KIND_PIXEL;
               result.red          = pix_merged[23:16];
               result.green        = pix_merged[15:8];
               result.blue         = pix_merged[7:0];
               result.alpha        = cur.bpp4 ? pix_merged[31:24] : 8'd0;
               result.repeat_count = count;
               st_in.pkt_left      = pkt_next;
               st_in.pix_left      = left_next;
               st_in.byte_idx      = 2'd0;
               st_in.pix           = 32'd0;
               if (left_next == 30'd0) begin
                  result.last = 1'b1;
                  st_in.phase = PH_IDLE;
               end else if (cur.rle && pkt_next == 8'd0) begin
                  st_in.phase = PH_PACKET;
               end
            end else begin
               st_in.pix      = pix_merged;
               st_in.byte_idx = cur.byte_idx + 2'd1;
            end
         end
         PH_IDLE: begin
            st_in = cur;
         end
         default: begin
            st_in = cur;
         end
      endcase

      // file ended before the image did
      if (final_byte && st_in.phase != PH_IDLE) begin
         result      = '0;
         result.kind = KIND_ERROR;
         result.err  = ERR_TRUNCATED;
         has_result  = 1'b1;
         st_in.phase = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

endmodule

### hw/rtl/tgard_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module tgard_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tgard_pkg::result_type load_result,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tgard_pkg::result_type rsp_result
);
   import tgard_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // slot can take a new word this cycle if empty or being drained
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

### hw/rtl/tga_rle_stream_decoder_unit.sv
// Path: input register, then the combinational parser, then the result register.
// Throughput: one file byte per cycle unless stalled; both registers are one word deep.
// Bytes that make no result (header, ID skip, packet headers, partial pixels) load no word.
// Stalls: rsp_ready low holds the result register, and req_ready drops once both are full.
// Reset (synchronous): empties both registers and returns the parser to header byte 0.
module tga_rle_stream_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic [14:0] rsp_image_width,
   output logic [14:0] rsp_image_height,
   output logic [5:0]  rsp_bits_per_pixel,
   output logic        rsp_needs_flip,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_pixel
);
   import tgard_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] byte_ff;
   logic       first_ff;
   logic       final_ff;
   logic       out_free;
   logic       step;
   logic       has_result;
   result_type result;
   result_type rsp_result;

   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff  <= req_file_byte;
         first_ff <= req_first_byte;
         final_ff <= req_final_byte;
      end
   end

   tgard_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .file_byte  (byte_ff),
      .first_byte (first_ff),
      .final_byte (final_ff),
      .has_result (has_result),
      .result     (result)
   );

   tgard_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (step && has_result),
      .load_result (result),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_result_kind    = rsp_result.kind;
   assign rsp_red            = rsp_result.red;
   assign rsp_green          = rsp_result.green;
   assign rsp_blue           = rsp_result.blue;
   assign rsp_alpha          = rsp_result.alpha;
   assign rsp_repeat_count   = rsp_result.repeat_count;
   assign rsp_image_width    = rsp_result.width;
   assign rsp_image_height   = rsp_result.height;
   assign rsp_bits_per_pixel = rsp_result.bpp;
   assign rsp_needs_flip     = rsp_result.flip;
   assign rsp_error_code     = rsp_result.err;
   assign rsp_last_pixel     = rsp_result.last;

endmodule

### hw/rtl/tgard_checker.sv
// Port-level checks for the decoder, bound to the top level.
module tgard_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_repeat_count,
   input logic [14:0] rsp_image_width,
   input logic [14:0] rsp_image_height,
   input logic [5:0]  rsp_bits_per_pixel,
   input logic [2:0]  rsp_error_code
);
   import tgard_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind))
      else $error("stalled result word dropped or changed");

   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_PIXEL |-> rsp_repeat_count != 8'd0
         && rsp_repeat_count <= 8'd128)
      else $error("pixel word with bad repeat count");

   a_header_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_HEADER |-> rsp_image_width != 15'd0
         && rsp_image_height != 15'd0
         && (rsp_bits_per_pixel == 6'd24 || rsp_bits_per_pixel == 6'd32))
      else $error("header word with bad geometry or depth");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_ERROR |-> rsp_error_code != ERR_NONE
         && rsp_error_code <= ERR_TRUNCATED)
      else $error("error word with bad code");

endmodule

bind tga_rle_stream_decoder_unit tgard_checker u_tgard_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_repeat_count   (rsp_repeat_count),
   .rsp_image_width    (rsp_image_width),
   .rsp_image_height   (rsp_image_height),
   .rsp_bits_per_pixel (rsp_bits_per_pixel),
   .rsp_error_code     (rsp_error_code)
);

### dv/tb_tga_rle_stream_decoder_unit.sv
// Self-checking testbench for the TGA truecolor run-length stream decoder unit.
`timescale 1ns / 100ps

module tb_tga_rle_stream_decoder_unit;
   import tgard_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no word moving on either side
   localparam int HOLD_OFF    = 300;    // long result-side stall
   localparam int RANDOM_BYTES = 440;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_file_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic [14:0] rsp_image_width;
   logic [14:0] rsp_image_height;
   logic [5:0]  rsp_bits_per_pixel;
   logic        rsp_needs_flip;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_pixel;

   tga_rle_stream_decoder_unit u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder shadow state
   phase_type   dec_phase;
   logic [4:0]  hdr_pos;
   logic [7:0]  id_to_skip;
   logic [63:0] corner_bytes;
   bit          rle_on;
   int          pix_size;
   bit          run_packet;
   logic [7:0]  packet_pixels;
   int          pix_byte_pos;
   logic [31:0] pix_word;
   int unsigned pixels_to_go;
   bit          flip_rows;
   logic [7:0]  cmap_seen;
   logic [7:0]  type_seen;
   logic [7:0]  depth_seen;

   result_type  decoded_due[$];
   logic [7:0]  tga_file[$];
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   int          rx_stall = 0;
   bit          tx_gaps_on = 1'b1;
   bit          rx_gaps_on = 1'b1;
   bit          hold_off_request = 1'b0;

   function automatic void restart_parser();
      dec_phase     = PH_HEADER;
      hdr_pos       = '0;
      id_to_skip    = '0;
      corner_bytes  = '0;
      rle_on        = 1'b0;
      pix_size      = 4;
      run_packet    = 1'b0;
      packet_pixels = '0;
      pix_byte_pos  = 0;
      pix_word      = '0;
      pixels_to_go  = 0;
      flip_rows     = 1'b0;
      cmap_seen     = '0;
      type_seen     = '0;
      depth_seen    = '0;
   endfunction

   function automatic void enter_pixel_data();
      dec_phase    = rle_on ? PH_PACKET : PH_PIXEL;
      run_packet   = 1'b0;
      pix_byte_pos = 0;
      pix_word     = '0;
   endfunction

   // Advances the shadow decoder by one file byte; returns 1 when a result is due.
   function automatic bit decode_tga_byte(input logic [7:0] b, input bit is_first,
                                          input bit is_last, output result_type res);
      bit          got;
      int          w;
      int          h;
      err_type     fault;
      int unsigned count;
      got = 1'b0;
      res = '0;
      if (is_first) restart_parser();
      if (dec_phase == PH_IDLE) return 1'b0;
      case (dec_phase)
         PH_HEADER: begin
            if (hdr_pos == HDR_ID_LEN) id_to_skip = b;
            else if (hdr_pos == HDR_CMAP) cmap_seen = b;
            else if (hdr_pos == HDR_TYPE) type_seen = b;
            else if (hdr_pos >= HDR_COORD0 && hdr_pos < HDR_DEPTH)
               corner_bytes[8 * (hdr_pos - HDR_COORD0) +: 8] = b;
            else if (hdr_pos == HDR_DEPTH) depth_seen = b;
            if (hdr_pos == HDR_LAST) begin
               w = int'(shortint'(corner_bytes[47:32])) - int'(shortint'(corner_bytes[15:0]));
               h = int'(shortint'(corner_bytes[63:48])) - int'(shortint'(corner_bytes[31:16]));
               fault = ERR_NONE;
               if (cmap_seen > 8'd1) fault = ERR_COLORMAP;
               else if (type_seen != TYPE_RAW && type_seen != TYPE_RLE) fault = ERR_ENCODING;
               else if (w < 1 || h < 1 || w > 32767 || h > 32767) fault = ERR_SIZE;
               else if (b > DESC_MAX || (depth_seen != DEPTH_24 && depth_seen != DEPTH_32))
                  fault = ERR_DEPTH;
               else if (cmap_seen != 8'd0) fault = ERR_COLORMAP;
               if (fault != ERR_NONE) begin
                  // a header fault wins over truncation on the same byte
                  res.kind = KIND_ERROR;
                  res.err = fault;
                  dec_phase = PH_IDLE;
                  return 1'b1;
               end
               rle_on = (type_seen == TYPE_RLE);
               pix_size = (depth_seen == DEPTH_32) ? 4 : 3;
               flip_rows = b[FLIP_BIT];
               pixels_to_go = w * h;
               res.kind = KIND_HEADER;
               res.width = w[14:0];
               res.height = h[14:0];
               res.bpp = depth_seen[5:0];
               res.flip = flip_rows;
               got = 1'b1;
               if (id_to_skip != 8'd0) dec_phase = PH_SKIP_ID;
               else enter_pixel_data();
            end else begin
               hdr_pos++;
            end
         end
         PH_SKIP_ID: begin
            id_to_skip--;
            if (id_to_skip == 8'd0) enter_pixel_data();
         end
         PH_PACKET: begin
            run_packet = b[RUN_BIT];
            packet_pixels = run_packet ? b - RUN_BIAS : b + 8'd1;
            dec_phase = PH_PIXEL;
            pix_byte_pos = 0;
            pix_word = '0;
         end
         default: begin
            pix_word[8 * pix_byte_pos +: 8] = b;
            if (pix_byte_pos + 1 >= pix_size) begin
               count = 1;
               if (rle_on && run_packet) begin
                  count = packet_pixels;
                  if (count > pixels_to_go) count = pixels_to_go;   // clip run at image end
                  packet_pixels = '0;
               end else if (rle_on && packet_pixels != 8'd0) begin
                  packet_pixels--;
               end
               res.kind = KIND_PIXEL;
               res.red = pix_word[23:16];
               res.green = pix_word[15:8];
               res.blue = pix_word[7:0];
               res.alpha = (pix_size == 4) ? pix_word[31:24] : 8'd0;
               res.repeat_count = count[7:0];
               pixels_to_go -= count;
               pix_byte_pos = 0;
               pix_word = '0;
               got = 1'b1;
               if (pixels_to_go == 0) begin
                  res.last = 1'b1;
                  dec_phase = PH_IDLE;
               end else if (rle_on && packet_pixels == 8'd0) begin
                  dec_phase = PH_PACKET;
               end
            end else begin
               pix_byte_pos++;
            end
         end
      endcase
      if (is_last && dec_phase != PH_IDLE) begin
         res = '0;
         res.kind = KIND_ERROR;
         res.err = ERR_TRUNCATED;
         dec_phase = PH_IDLE;
         return 1'b1;
      end
      return got;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pixel_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_file_byte(input logic [7:0] value, input bit is_first, input bit is_last);
      result_type outcome;
      int gap;
      req_valid <= 1'b1;
      req_file_byte <= value;
      req_first_byte <= is_first;
      req_final_byte <= is_last;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (decode_tga_byte(value, is_first, is_last, outcome)) decoded_due.push_back(outcome);
      bytes_sent++;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_due.size() != 0) @(posedge clock);
   endtask

   task automatic begin_header(input int id_len, input logic [7:0] cmap, input logic [7:0] itype,
                               input logic [15:0] x0, input logic [15:0] y0,
                               input logic [15:0] x1, input logic [15:0] y1,
                               input logic [7:0] depth, input logic [7:0] desc);
      tga_file = {};
      tga_file.push_back(8'(id_len));
      tga_file.push_back(cmap);
      tga_file.push_back(itype);
      repeat (5) tga_file.push_back(8'($urandom_range(0, 255)));   // color map spec
      tga_file.push_back(x0[7:0]);
      tga_file.push_back(x0[15:8]);
      tga_file.push_back(y0[7:0]);
      tga_file.push_back(y0[15:8]);
      tga_file.push_back(x1[7:0]);
      tga_file.push_back(x1[15:8]);
      tga_file.push_back(y1[7:0]);
      tga_file.push_back(y1[15:8]);
      tga_file.push_back(depth);
      tga_file.push_back(desc);
      repeat (id_len) tga_file.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_raw_pixels(input int npix, input int bpp_bytes);
      repeat (npix * bpp_bytes) tga_file.push_back(pixel_byte());
   endtask

   // Packets covering npix pixels; overshoot lets some packets run past the image end.
   task automatic add_rle_packets(input int npix, input int bpp_bytes, input bit overshoot);
      int left;
      int len;
      left = npix;
      while (left > 0) begin
         len = $urandom_range(1, (left < 128) ? left : 128);
         if (overshoot && left < 124 && $urandom_range(0, 4) == 0)
            len = $urandom_range(left + 1, left + 4);
         if ($urandom_range(0, 1)) begin
            tga_file.push_back(8'(RUN_BIAS + len));
            add_raw_pixels(1, bpp_bytes);
         end else begin
            tga_file.push_back(8'(len - 1));
            add_raw_pixels(len, bpp_bytes);
         end
         left -= len;
      end
   endtask

   // cut of 0 sends the whole file
   task automatic send_tga(input int cut, input bit mark_last);
      int n;
      n = (cut > 0 && cut < tga_file.size()) ? cut : tga_file.size();
      for (int i = 0; i < n; i++) send_file_byte(tga_file[i], i == 0, mark_last && i == n - 1);
   endtask

   task automatic test_header_checks();
      // colormap type above 1 is reported ahead of a bad image type
      begin_header(0, 8'd2, 8'd3, 16'd0, 16'd0, 16'd4, 16'd4, DEPTH_24, 8'd0);
      send_tga(0, 1'b1);
      // bad image type is reported ahead of colormap type 1
      begin_header(0, 8'd1, 8'd3, 16'd0, 16'd0, 16'd4, 16'd4, DEPTH_24, 8'd0);
      send_tga(0, 1'b0);
      begin_header(0, 8'd1, TYPE_RAW, 16'd0, 16'd0, 16'd2, 16'd2, DEPTH_24, 8'd0);
      send_tga(0, 1'b1);
      // zero width, width 32768, negative height
      begin_header(0, 8'd0, TYPE_RLE, 16'd5, 16'd0, 16'd5, 16'd3, DEPTH_32, 8'd0);
      send_tga(0, 1'b0);
      begin_header(0, 8'd0, TYPE_RAW, 16'h8000, 16'd0, 16'd0, 16'd1, DEPTH_24, 8'd0);
      send_tga(0, 1'b0);
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd9, 16'd2, 16'd4, DEPTH_24, 8'd0);
      send_tga(0, 1'b0);
      // descriptor over the limit, unsupported depth
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd1, 16'd1, DEPTH_24, DESC_MAX + 8'd1);
      send_tga(0, 1'b0);
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd1, 16'd1, 8'd16, 8'd0);
      send_tga(0, 1'b0);
      // largest legal sizes: one left open (restarted later), one cut short by final
      begin_header(0, 8'd0, TYPE_RAW, 16'hFFFF, 16'd0, 16'd32766, 16'd1, DEPTH_32, DESC_MAX);
      send_tga(0, 1'b0);
      begin_header(0, 8'd0, TYPE_RLE, 16'd0, 16'h8001, 16'd1, 16'd0, DEPTH_24,
                   8'(1 << FLIP_BIT));
      send_tga(0, 1'b1);
   endtask

   task automatic test_raw_images();
      begin_header(0, 8'd0, TYPE_RAW, 16'd10, 16'd20, 16'd12, 16'd21, DEPTH_24,
                   8'(1 << FLIP_BIT));
      repeat (3) tga_file.push_back(8'h00);
      repeat (3) tga_file.push_back(8'hFF);
      send_tga(0, 1'b1);
      begin_header(3, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd1, 16'd1, DEPTH_32, 8'd0);
      tga_file.push_back(8'h11);
      tga_file.push_back(8'h22);
      tga_file.push_back(8'h33);
      tga_file.push_back(8'h44);
      send_tga(0, 1'b1);
      // words after a finished image are dropped
      repeat (3) send_file_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd3, 16'd2, DEPTH_32, 8'd0);
      add_raw_pixels(6, 4);
      send_tga(0, 1'b1);
   endtask

   task automatic test_rle_packets();
      // longest run, clipped to a three pixel image
      begin_header(0, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd3, 16'd1, DEPTH_24, 8'd0);
      tga_file.push_back(8'(RUN_BIAS + 128));
      add_raw_pixels(1, 3);
      send_tga(0, 1'b1);
      begin_header(0, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd128, 16'd1, DEPTH_32, 8'd0);
      tga_file.push_back(8'(RUN_BIAS + 128));
      add_raw_pixels(1, 4);
      send_tga(0, 1'b1);
      // raw, run, then a raw packet that reaches past the image end
      begin_header(0, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd4, 16'd2, DEPTH_32, 8'd0);
      tga_file.push_back(8'd1);
      add_raw_pixels(2, 4);
      tga_file.push_back(8'(RUN_BIAS + 3));
      add_raw_pixels(1, 4);
      tga_file.push_back(8'd127);
      add_raw_pixels(5, 4);
      send_tga(0, 1'b1);
      begin_header(2, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd2, 16'd1, DEPTH_24, 8'd0);
      tga_file.push_back(8'd127);
      add_raw_pixels(2, 3);
      send_tga(0, 1'b1);
   endtask

   task automatic test_truncation();
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd2, 16'd2, DEPTH_24, 8'd0);
      add_raw_pixels(4, 3);
      send_tga(23, 1'b1);                 // ends inside the second pixel
      begin_header(5, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd4, 16'd1, DEPTH_24, 8'd0);
      add_rle_packets(4, 3, 1'b0);
      send_tga(20, 1'b1);                 // ends inside the ID field
      begin_header(0, 8'd0, TYPE_RLE, 16'd0, 16'd0, 16'd2, 16'd1, DEPTH_32, 8'd0);
      add_rle_packets(2, 4, 1'b0);
      send_tga(19, 1'b1);                 // ends on the packet header
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd1, 16'd1, DEPTH_24, 8'd0);
      send_tga(6, 1'b1);                  // ends inside the header
      repeat (2) send_file_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      // a new file starts in the middle of pixel data
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd3, 16'd1, DEPTH_32, 8'd0);
      add_raw_pixels(3, 4);
      send_tga(23, 1'b0);
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd1, 16'd2, DEPTH_24, 8'd0);
      add_raw_pixels(2, 3);
      send_tga(0, 1'b1);
      wait_results_drained();
   endtask

   task automatic test_backpressure();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      hold_off_request = 1'b1;
      begin_header(0, 8'd0, TYPE_RAW, 16'd0, 16'd0, 16'd6, 16'd3, DEPTH_24, 8'd0);
      add_raw_pixels(18, 3);
      send_tga(0, 1'b1);
      wait_results_drained();
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   task automatic test_random_files();
      int          stop_at;
      int          bpp_bytes;
      int          w;
      int          h;
      int          id_len;
      int          pick;
      bit          use_rle;
      logic [7:0]  cmap;
      logic [7:0]  itype;
      logic [7:0]  depth;
      logic [7:0]  desc;
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] x1;
      logic [15:0] y1;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on = ($urandom_range(0, 3) != 0);
         bpp_bytes = $urandom_range(0, 1) ? 4 : 3;
         use_rle = ($urandom_range(0, 2) != 0);
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(7, 20);
            h = 1;
         end
         pick = $urandom_range(0, 99);
         id_len = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 4) : $urandom_range(5, 12);
         cmap = 8'd0;
         itype = use_rle ? TYPE_RLE : TYPE_RAW;
         depth = 8'(bpp_bytes * 8);
         desc = 8'($urandom_range(0, 32));
         x0 = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000) - 1000);
         y0 = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000) - 1000);
         x1 = x0 + 16'(w);
         y1 = y0 + 16'(h);
         // occasional broken header
         pick = $urandom_range(0, 99);
         if (pick < 3) cmap = 8'($urandom_range(1, 255));
         else if (pick < 6) itype = 8'($urandom_range(0, 255));
         else if (pick < 9) depth = 8'($urandom_range(0, 255));
         else if (pick < 11) desc = 8'($urandom_range(33, 255));
         else if (pick < 13) x1 = x0 - 16'(w);
         begin_header(id_len, cmap, itype, x0, y0, x1, y1, depth, desc);
         if (use_rle) add_rle_packets(w * h, bpp_bytes, 1'b1);
         else add_raw_pixels(w * h, bpp_bytes);
         pick = $urandom_range(0, 99);
         if (pick < 72) send_tga(0, 1'b1);
         else if (pick < 82) send_tga(0, 1'b0);
         else if (pick < 94) send_tga($urandom_range(1, tga_file.size() - 1), 1'b1);
         else send_tga($urandom_range(1, tga_file.size() - 1), 1'b0);
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3))
               send_file_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rx_stall = HOLD_OFF;
      end else if (rx_stall == 0 && rx_gaps_on) begin
         rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
         rsp_ready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 100)
            $display("%0t: %s expected %0d actual %0d", $time, nm, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 100)
               $display("%0t: result word with none expected, kind %0d", $time, rsp_result_kind);
         end else begin
            want = decoded_due.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
            check_field("repeat_count", want.repeat_count, rsp_repeat_count);
            check_field("image_width", want.width, rsp_image_width);
            check_field("image_height", want.height, rsp_image_height);
            check_field("bits_per_pixel", want.bpp, rsp_bits_per_pixel);
            check_field("needs_flip", want.flip, rsp_needs_flip);
            check_field("error_code", want.err, rsp_error_code);
            check_field("last_pixel", want.last, rsp_last_pixel);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      restart_parser();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_header_checks();
      test_raw_images();
      test_rle_packets();
      test_truncation();
      test_backpressure();
      test_random_files();
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && decoded_due.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### tga_rle_stream_decoder_unit.f
hw/rtl/tgard_pkg.sv
hw/rtl/tgard_parser.sv
hw/rtl/tgard_out_reg.sv
hw/rtl/tga_rle_stream_decoder_unit.sv
hw/rtl/tgard_checker.sv
dv/tb_tga_rle_stream_decoder_unit.sv
